>>> rtl/srev_pkg.sv
// Shared constants and types for the stream group reverser.
package srev_pkg;

	localparam int CFG_W          = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;
	localparam int GROUP_MAX_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int CNT_MAX_W      = 7;

	typedef struct packed {
		logic                 bank;
		logic [CNT_MAX_W-1:0] count;
		logic                 rev;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

>>> rtl/stream_group_reverser_core.sv
// Top level of the stream group reverser.
//
//   Channel   Direction  Signals                       Contents
//   s_        in         tvalid tready tdata tlast     value, end of list
//   m_        out        tvalid tready tdata tlast     reordered value, last of run
//   cfg_      in         wr_en wr_data                 group size
//
// A word is stored as it is taken; a completed group is read back from a two-bank
// buffer at one word per cycle through the single read port while the output is
// not stalled. The front end fills one bank while the back end drains the other,
// and stalls only when both banks are still owed. Reset returns the control logic
// to idle and sets the group size to 2; the buffer itself needs no clearing.
module stream_group_reverser_core import srev_pkg::*; #(
	parameter int GROUP_MAX  = GROUP_MAX_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8,
	localparam int SLOT_W  = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CFG_W-1:0]   cfg_wr_data,  // group_size
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,      // value
	input  logic               s_tlast,      // end_of_list
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,      // out_value
	output logic               m_tlast       // run_last
);

	logic                  wr_en;
	logic [SLOT_W:0]       wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic                  rd_en;
	logic [SLOT_W:0]       rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  cmd_valid;
	cmd_t                  cmd;
	logic                  q_valid;
	cmd_t                  q_cmd;
	logic                  q_pop;
	rel_t                  rel;
	logic [DATA_WIDTH-1:0] out_value;

	srev_front #(
		.GROUP_MAX (GROUP_MAX),
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_value   (s_tdata[DATA_WIDTH-1:0]),
		.in_last    (s_tlast),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.rel        (rel)
	);

	srev_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(2 << SLOT_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	srev_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_valid),
		.push_cmd(cmd),
		.pop     (q_pop),
		.valid   (q_valid),
		.head    (q_cmd)
	);

	srev_back #(
		.GROUP_MAX (GROUP_MAX),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.rel      (rel),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_value(out_value),
		.out_last (m_tlast)
	);

	assign m_tdata = TDATA_W'(out_value);

endmodule

>>> rtl/srev_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srev_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/srev_front.sv
// Front end: takes words, stores them in the current bank and issues group commands.
module srev_front import srev_pkg::*; #(
	parameter int GROUP_MAX  = GROUP_MAX_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int CNT_W  = $clog2(GROUP_MAX + 1),
	localparam int SLOT_W = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_W-1:0]      cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] in_value,
	input  logic                  in_last,
	output logic                  wr_en,
	output logic [SLOT_W:0]       wr_addr,
	output logic [DATA_WIDTH-1:0] wr_data,
	output logic                  cmd_valid,
	output cmd_t                  cmd,
	input  rel_t                  rel
);

	localparam int KW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [CFG_W-1:0] group_size_q;
	logic [CNT_W-1:0] fill_q;
	logic             bank_q;
	logic [1:0]       busy_q;
	logic [KW-1:0]    gs_ext;
	logic [KW-1:0]    k;
	logic [KW-1:0]    n_ext;
	logic             accept;
	logic             done;

	assign in_ready = !busy_q[bank_q];
	assign accept   = in_valid && in_ready;

	assign gs_ext = KW'(group_size_q);
	always_comb begin
		if (group_size_q == '0) begin
			k = KW'(1);
		end else if (gs_ext > KW'(GROUP_MAX)) begin
			k = KW'(GROUP_MAX);
		end else begin
			k = gs_ext;
		end
	end

	assign n_ext = KW'(fill_q) + KW'(1);
	assign done  = n_ext >= k;

	assign wr_en   = accept;
	assign wr_addr = {bank_q, fill_q[SLOT_W-1:0]};
	assign wr_data = in_value;

	assign cmd_valid = accept && (done || in_last);
	assign cmd.bank  = bank_q;
	assign cmd.count = CNT_MAX_W'(n_ext);
	assign cmd.rev   = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= CFG_RESET;
			fill_q       <= '0;
			bank_q       <= 1'b0;
			busy_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				group_size_q <= cfg_wr_data;
			end
			if (accept) begin
				if (cmd_valid) begin
					fill_q <= '0;
					bank_q <= !bank_q;
				end else begin
					fill_q <= n_ext[CNT_W-1:0];
				end
			end
			for (int b = 0; b < 2; b++) begin
				if (cmd_valid && (bank_q == 1'(b))) begin
					busy_q[b] <= 1'b1;
				end else if (rel.valid && (rel.bank == 1'(b))) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

endmodule

>>> rtl/srev_cmdq.sv
// Two-entry command queue between the front end and the back end.
module srev_cmdq import srev_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	cmd_t       entry_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign valid = cnt_q != 2'd0;
	assign head  = entry_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> rtl/srev_back.sv
// Back end: reads a committed bank in the commanded order and streams the words out.
module srev_back import srev_pkg::*; #(
	parameter int GROUP_MAX  = GROUP_MAX_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int CNT_W  = $clog2(GROUP_MAX + 1),
	localparam int SLOT_W = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  cmd_t                  q_cmd,
	output logic                  q_pop,
	output logic                  rd_en,
	output logic [SLOT_W:0]       rd_addr,
	input  logic [DATA_WIDTH-1:0] rd_data,
	output rel_t                  rel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] out_value,
	output logic                  out_last
);

	logic                  active_q;
	logic                  bank_q;
	logic                  rev_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      idx_q;
	logic                  inflight_s1;
	logic                  last_s1;
	logic [DATA_WIDTH-1:0] data_q [2];
	logic                  flag_q [2];
	logic                  wp_q;
	logic                  rp_q;
	logic [1:0]            occ_q;
	logic                  pop_out;
	logic                  room;
	logic                  issue;
	logic                  last_rd;
	logic [CNT_W-1:0]      slot;

	assign out_valid = occ_q != 2'd0;
	assign out_value = data_q[rp_q];
	assign out_last  = flag_q[rp_q];
	assign pop_out   = out_valid && out_ready;

	assign room    = (3'(occ_q) + 3'(inflight_s1)) <= (3'd1 + 3'(pop_out));
	assign issue   = active_q && room;
	assign last_rd = idx_q == (cnt_q - CNT_W'(1));
	assign q_pop   = q_valid && (!active_q || (issue && last_rd));

	assign slot    = rev_q ? (cnt_q - CNT_W'(1) - idx_q) : idx_q;
	assign rd_en   = issue;
	assign rd_addr = {bank_q, slot[SLOT_W-1:0]};

	assign rel.valid = issue && last_rd;
	assign rel.bank  = bank_q;

	always_ff @(posedge clk) begin
		last_s1 <= last_rd;
		if (inflight_s1) begin
			data_q[wp_q] <= rd_data;
			flag_q[wp_q] <= last_s1;
		end
		if (q_pop) begin
			bank_q <= q_cmd.bank;
			rev_q  <= q_cmd.rev;
			cnt_q  <= q_cmd.count[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			inflight_s1 <= 1'b0;
			wp_q        <= 1'b0;
			rp_q        <= 1'b0;
			occ_q       <= '0;
		end else begin
			priority if (q_pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (issue) begin
				if (last_rd) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end else begin
				active_q <= active_q;
			end
			inflight_s1 <= issue;
			if (inflight_s1) begin
				wp_q <= !wp_q;
			end
			if (pop_out) begin
				rp_q <= !rp_q;
			end
			occ_q <= occ_q + 2'(inflight_s1) - 2'(pop_out);
		end
	end

endmodule

>>> rtl/srev_checker.sv
// Port-level checks for the stream group reverser, bound to the top level.
module srev_checker #(
	parameter int TDATA_W = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tlast
);

	logic seen_in_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			seen_in_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("Output word changed while stalled.");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("Output word offered straight after reset.");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> seen_in_q)
		else $error("Output word offered before any input word was taken.");

endmodule

bind stream_group_reverser_core srev_checker #(
	.TDATA_W(TDATA_W)
) u_srev_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
